// File: rtl/apt_pkg.sv
// Shared constants for the 2D affine point transform: formats and register indexes.
`default_nettype none
package apt_pkg;

  // Fraction bits of the signed Q16.16 coordinate and coefficient format.
  localparam int unsigned FRAC_BITS = 16;

  // Rounding bias that turns an arithmetic shift into truncation toward zero.
  localparam int unsigned TRUNC_BIAS = (1 << FRAC_BITS) - 1;

  // Width of the singular limit register, and so of the configuration data.
  localparam int unsigned LIMIT_WIDTH = 62;

  // Configuration register index width.
  localparam int unsigned CFG_IDX_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_XX  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_XY  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_YX  = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_YY  = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SING_LIM = 3'd6;

  // Reset values: unit coefficient and a limit of about 1e-8 in Q32.32.
  localparam logic [63:0] COEF_ONE      = 64'd65536;
  localparam logic [LIMIT_WIDTH-1:0] SING_LIM_RESET = 62'd43;

endpackage
`default_nettype wire

// File: rtl/affine_point_transform_2d.sv
// Top level of the pipelined 2D affine point transform, forward and inverse.
//
// Usage: each input word carries op (0 forward, 1 inverse) and a point in_x, in_y
// in signed Q16.16. Each accepted word yields exactly one output word with out_x,
// out_y and singular. Both channels use valid/ready. The matrix and the singular
// limit are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while no word is
// in flight; writes to unused indexes are ignored.
// Throughput: one word per cycle while the skid register is empty. The pipeline
// ends in the inverse divider, which resolves one quotient bit per stage for both
// coordinates, behind six stages of input, offset, multiply, sum, magnitude and
// overflow check.
// Reset clears all valid bits, so the pipeline comes up empty, and loads the
// identity matrix with a singular limit of 43 (Q32.32).
// When the receiver stalls, the word in flight lands in a skid register and the
// whole pipeline then holds still; nothing is dropped or repeated, and input
// ready returns as soon as the skid register drains.
`default_nettype none
module affine_point_transform_2d #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [apt_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  wire logic [apt_pkg::LIMIT_WIDTH-1:0]      cfg_wdata_i,
  // Input channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 op_i,
  input  wire logic [COORD_WIDTH-1:0]               in_x_i,
  input  wire logic [COORD_WIDTH-1:0]               in_y_i,
  // Output channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic      [COORD_WIDTH-1:0]               out_x_o,
  output logic      [COORD_WIDTH-1:0]               out_y_o,
  output logic                                      singular_o
);
  import apt_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned M  = 2 * W + 1;            // products and determinant
  localparam int unsigned A  = 2 * W + 3;            // accumulated sums
  localparam int unsigned RW = 2 * W;                // divisor magnitude and remainder
  localparam int unsigned NW = M + FRAC_BITS;        // scaled dividend
  localparam int unsigned LW = (RW > LIMIT_WIDTH) ? RW : LIMIT_WIDTH;
  localparam int unsigned NS = W + 6;                // pipeline stages before the output

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // Truncate a Q32.32 sum toward zero into Q16.16 and saturate.
  function automatic logic [W-1:0] fwd_result(input logic [A-1:0] sum);
    logic signed [A-1:0] t;
    logic [A-W:0]        top;
    logic [W-1:0]        r;
    t   = ($signed(sum) + $signed(A'(TRUNC_BIAS) & {A{sum[A-1]}})) >>> FRAC_BITS;
    top = t[A-1:W-1];
    if ((&top) || !(|top)) begin
      r = t[W-1:0];
    end else begin
      r = t[A-1] ? MINV : MAXV;
    end
    return r;
  endfunction

  // Apply the quotient sign and saturate.
  function automatic logic [W-1:0] div_result(input logic [W-1:0] q, input logic ov,
                                              input logic neg);
    logic [W-1:0] r;
    if (neg) begin
      r = (ov || (q[W-1] && (|q[W-2:0]))) ? MINV : (~q + 1'b1);
    end else begin
      r = (ov || q[W-1]) ? MAXV : q;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [W-1:0]           coef_xx_q, coef_xy_q, offset_x_q;
  logic [W-1:0]           coef_yx_q, coef_yy_q, offset_y_q;
  logic [LIMIT_WIDTH-1:0] sing_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= COEF_ONE[W-1:0];
      coef_xy_q  <= '0;
      offset_x_q <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= COEF_ONE[W-1:0];
      offset_y_q <= '0;
      sing_lim_q <= SING_LIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_XX:  coef_xx_q  <= cfg_wdata_i[W-1:0];
        REG_COEF_XY:  coef_xy_q  <= cfg_wdata_i[W-1:0];
        REG_OFFSET_X: offset_x_q <= cfg_wdata_i[W-1:0];
        REG_COEF_YX:  coef_yx_q  <= cfg_wdata_i[W-1:0];
        REG_COEF_YY:  coef_yy_q  <= cfg_wdata_i[W-1:0];
        REG_OFFSET_Y: offset_y_q <= cfg_wdata_i[W-1:0];
        REG_SING_LIM: sing_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: the whole pipeline holds while the skid register is full.
  logic          skid_v_q;
  logic          en;
  logic [NS-1:0] v_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Stage 0: input register.
  logic         op0_q;
  logic [W-1:0] x0_q, y0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= op_i;
      x0_q  <= in_x_i;
      y0_q  <= in_y_i;
    end
  end

  // Stage 1: remove the translation for the inverse, pick multiplier operands.
  logic       op1_q;
  logic [W:0] a1_q, b1_q;
  logic [W:0] gx, gy;

  assign gx = (W+1)'($signed(x0_q)) - (W+1)'($signed(offset_x_q));
  assign gy = (W+1)'($signed(y0_q)) - (W+1)'($signed(offset_y_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= op0_q;
      a1_q  <= op0_q ? gx : (W+1)'($signed(x0_q));
      b1_q  <= op0_q ? gy : (W+1)'($signed(y0_q));
    end
  end

  // Stage 2: the four point products and the two determinant products.
  logic          op2_q;
  logic [M-1:0]  ma_q, mb_q, mc_q, md_q;
  logic [RW-1:0] p1_q, p2_q;
  logic [W:0]    opa, opd;

  assign opa = op1_q ? b1_q : a1_q;
  assign opd = op1_q ? a1_q : b1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q <= op1_q;
      ma_q  <= M'($signed(coef_xx_q)) * M'($signed(opa));
      mb_q  <= M'($signed(coef_xy_q)) * M'($signed(b1_q));
      mc_q  <= M'($signed(coef_yx_q)) * M'($signed(a1_q));
      md_q  <= M'($signed(coef_yy_q)) * M'($signed(opd));
      p1_q  <= RW'($signed(coef_xx_q)) * RW'($signed(coef_yy_q));
      p2_q  <= RW'($signed(coef_xy_q)) * RW'($signed(coef_yx_q));
    end
  end

  // Stage 3: forward sums with offsets, or inverse numerators and the determinant.
  logic         op3_q;
  logic [A-1:0] sx3_q, sy3_q;
  logic [M-1:0] det3_q;
  logic [A-1:0] offx_sh, offy_sh;

  assign offx_sh = {(A-FRAC_BITS)'($signed(offset_x_q)), {FRAC_BITS{1'b0}}};
  assign offy_sh = {(A-FRAC_BITS)'($signed(offset_y_q)), {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en) begin
      op3_q <= op2_q;
      if (op2_q) begin
        sx3_q <= A'($signed(md_q)) - A'($signed(mb_q));
        sy3_q <= A'($signed(ma_q)) - A'($signed(mc_q));
      end else begin
        sx3_q <= A'($signed(ma_q)) + A'($signed(mb_q)) + offx_sh;
        sy3_q <= A'($signed(mc_q)) + A'($signed(md_q)) + offy_sh;
      end
      det3_q <= M'($signed(p1_q)) - M'($signed(p2_q));
    end
  end

  // Stage 4: forward results, magnitudes and signs, singular test.
  logic          op4_q, sing4_q, negx4_q, negy4_q;
  logic [W-1:0]  fx4_q, fy4_q;
  logic [M-1:0]  nx4_q, ny4_q;
  logic [RW-1:0] dm4_q;
  logic [A-1:0]  sxa, sya;
  logic [M-1:0]  dabs;
  logic [LW-1:0] dm_l, lim_l;

  assign sxa   = sx3_q[A-1] ? (~sx3_q + 1'b1) : sx3_q;
  assign sya   = sy3_q[A-1] ? (~sy3_q + 1'b1) : sy3_q;
  assign dabs  = det3_q[M-1] ? (~det3_q + 1'b1) : det3_q;
  assign dm_l  = LW'(dabs[RW-1:0]);
  assign lim_l = LW'(sing_lim_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      op4_q   <= op3_q;
      sing4_q <= (det3_q == '0) || (dm_l < lim_l);
      negx4_q <= sx3_q[A-1] ^ det3_q[M-1];
      negy4_q <= sy3_q[A-1] ^ det3_q[M-1];
      fx4_q   <= fwd_result(sx3_q);
      fy4_q   <= fwd_result(sy3_q);
      nx4_q   <= sxa[M-1:0];
      ny4_q   <= sya[M-1:0];
      dm4_q   <= dabs[RW-1:0];
    end
  end

  // Divider stages: index 0 holds the overflow check, 1..W one quotient bit each.
  logic          dop_q  [0:W];
  logic          dsing_q[0:W];
  logic          dnegx_q[0:W];
  logic          dnegy_q[0:W];
  logic [W-1:0]  dfx_q  [0:W];
  logic [W-1:0]  dfy_q  [0:W];
  logic [RW-1:0] dden_q [0:W];
  logic [W-1:0]  dnlx_q [0:W];
  logic [W-1:0]  dnly_q [0:W];
  logic [RW-1:0] drx_q  [0:W];
  logic [RW-1:0] dry_q  [0:W];
  logic [W-1:0]  dqx_q  [0:W];
  logic [W-1:0]  dqy_q  [0:W];
  logic          dovx_q [0:W];
  logic          dovy_q [0:W];

  logic [NW-1:0]    nfx, nfy;
  logic [NW+RW-1:0] hix, hiy, den_w;

  assign nfx   = {nx4_q, {FRAC_BITS{1'b0}}};
  assign nfy   = {ny4_q, {FRAC_BITS{1'b0}}};
  assign hix   = (NW+RW)'(nfx) >> W;
  assign hiy   = (NW+RW)'(nfy) >> W;
  assign den_w = (NW+RW)'(dm4_q);

  // Quotient overflow when the dividend's upper part already reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dop_q[0]   <= op4_q;
      dsing_q[0] <= sing4_q;
      dnegx_q[0] <= negx4_q;
      dnegy_q[0] <= negy4_q;
      dfx_q[0]   <= fx4_q;
      dfy_q[0]   <= fy4_q;
      dden_q[0]  <= dm4_q;
      dnlx_q[0]  <= nfx[W-1:0];
      dnly_q[0]  <= nfy[W-1:0];
      drx_q[0]   <= hix[RW-1:0];
      dry_q[0]   <= hiy[RW-1:0];
      dqx_q[0]   <= '0;
      dqy_q[0]   <= '0;
      dovx_q[0]  <= (hix >= den_w);
      dovy_q[0]  <= (hiy >= den_w);
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_div
    logic [RW-1:0] rx_n, ry_n;
    logic          qx_b, qy_b;

    apt_div_step #(.REM_WIDTH(RW)) u_step_x (
      .rem_i (drx_q[j-1]),
      .bit_i (dnlx_q[j-1][W-j]),
      .den_i (dden_q[j-1]),
      .rem_o (rx_n),
      .q_o   (qx_b)
    );

    apt_div_step #(.REM_WIDTH(RW)) u_step_y (
      .rem_i (dry_q[j-1]),
      .bit_i (dnly_q[j-1][W-j]),
      .den_i (dden_q[j-1]),
      .rem_o (ry_n),
      .q_o   (qy_b)
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        dop_q[j]   <= dop_q[j-1];
        dsing_q[j] <= dsing_q[j-1];
        dnegx_q[j] <= dnegx_q[j-1];
        dnegy_q[j] <= dnegy_q[j-1];
        dfx_q[j]   <= dfx_q[j-1];
        dfy_q[j]   <= dfy_q[j-1];
        dden_q[j]  <= dden_q[j-1];
        dnlx_q[j]  <= dnlx_q[j-1];
        dnly_q[j]  <= dnly_q[j-1];
        drx_q[j]   <= rx_n;
        dry_q[j]   <= ry_n;
        dqx_q[j]   <= {dqx_q[j-1][W-2:0], qx_b};
        dqy_q[j]   <= {dqy_q[j-1][W-2:0], qy_b};
        dovx_q[j]  <= dovx_q[j-1];
        dovy_q[j]  <= dovy_q[j-1];
      end
    end
  end

  // Final selection: forward result, signed quotient, or zeros when singular.
  logic [W-1:0] res_x, res_y;
  logic         res_s;
  logic         take, pop;

  always_comb begin
    if (!dop_q[W]) begin
      res_x = dfx_q[W];
      res_y = dfy_q[W];
      res_s = 1'b0;
    end else if (dsing_q[W]) begin
      res_x = '0;
      res_y = '0;
      res_s = 1'b1;
    end else begin
      res_x = div_result(dqx_q[W], dovx_q[W], dnegx_q[W]);
      res_y = div_result(dqy_q[W], dovy_q[W], dnegy_q[W]);
      res_s = 1'b0;
    end
  end

  assign take = en && v_q[NS-1];
  assign pop  = out_valid_o && out_ready_i;

  // Output register with a skid register behind it.
  logic [W-1:0] skid_x_q, skid_y_q;
  logic         skid_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (take) begin
      if (out_valid_o && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_valid_o <= 1'b1;
      end
    end else if (pop) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_x_o    <= skid_x_q;
        out_y_o    <= skid_y_q;
        singular_o <= skid_s_q;
      end
    end else if (take) begin
      if (out_valid_o && !pop) begin
        skid_x_q <= res_x;
        skid_y_q <= res_y;
        skid_s_q <= res_s;
      end else begin
        out_x_o    <= res_x;
        out_y_o    <= res_y;
        singular_o <= res_s;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/apt_div_step.sv
// One restoring division step: shifts in a dividend bit and subtracts the divisor.
`default_nettype none
module apt_div_step #(
  parameter int unsigned REM_WIDTH = 64
) (
  input  wire logic [REM_WIDTH-1:0] rem_i,
  input  wire logic                 bit_i,
  input  wire logic [REM_WIDTH-1:0] den_i,
  output logic      [REM_WIDTH-1:0] rem_o,
  output logic                      q_o
);
  import apt_pkg::*;

  logic [REM_WIDTH:0] trial;
  logic [REM_WIDTH:0] diff;

  // The partial remainder stays below the divisor, so the shifted value is below twice it.
  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, den_i};
  assign q_o   = (trial >= {1'b0, den_i});
  assign rem_o = q_o ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];

endmodule
`default_nettype wire
